/* rtl/tsfi_pkg.sv */
// Shared types and constants for the timestamp to frame index converter.
`default_nettype none

package tsfi_pkg;

   localparam int NumBits = 95;   // |time_value| * frame_timescale
   localparam int DenBits = 62;   // time_scale * frame_value
   localparam int CfgBits = 31;

   localparam logic [1:0] FUNC_FLOOR = 2'd0;
   localparam logic [1:0] FUNC_CEIL  = 2'd1;
   localparam logic [1:0] FUNC_ROUND = 2'd2;

   localparam logic CSR_FRAME_VALUE     = 1'b0;
   localparam logic CSR_FRAME_TIMESCALE = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK  = 2'd0,
      STATUS_BAD = 2'd1,
      STATUS_SAT = 2'd2
   } status_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [63:0] time_value;
      logic signed [31:0] time_scale;
      logic               time_numeric;
   } req_type;

   typedef struct packed {
      logic signed [63:0] frame_index;
      logic               on_grid;
      status_type         status;
   } rsp_type;

   // side information that rides along the divider
   typedef struct packed {
      logic [1:0] func;
      logic       neg;
      logic       bad;
   } side_type;

endpackage

`default_nettype wire

/* rtl/timestamp_to_frame_index.sv */
// Top level: rational timestamp to snapped frame index, fully pipelined.
`default_nettype none

//  channel | direction | handshake               | payload
//  req     | in        | req_valid / req_stall   | req_type (func, time, scale, numeric)
//  rsp     | out       | rsp_valid / rsp_stall   | rsp_type (frame_index, on_grid, status)
//  csr     | in        | csr_valid / csr_ready   | csr_index, csr_data[30:0]
//
//  One item per cycle while no result is stalled; 3 front stages, 95 divider stages,
//  output register with rounding in front of it. The divider does one
//  quotient bit per stage, which sets the depth.
//  Synchronous reset clears the valid bits; config resets to 1 / 30.
//  A stalled result freezes the whole pipeline; nothing is dropped or repeated.

module timestamp_to_frame_index
   import tsfi_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire req_type     req_payload,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output rsp_type          rsp_payload,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);

   // ---------------- configuration ----------------
   logic [CfgBits-1:0] frame_value_ff, frame_timescale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_value_ff     <= CfgBits'(1);
         frame_timescale_ff <= CfgBits'(30);
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FRAME_VALUE:     frame_value_ff     <= csr_data[CfgBits-1:0];
            CSR_FRAME_TIMESCALE: frame_timescale_ff <= csr_data[CfgBits-1:0];
            default:             ;
         endcase
      end
   end

   // global advance: everything moves unless a result is held
   logic advance;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // ---------------- stage A: checks and magnitude ----------------
   logic               a_valid_ff;
   side_type           a_side_ff, a_side_in;
   logic [63:0]        a_mag_ff, a_mag_in;
   logic [CfgBits-1:0] a_ts_ff;

   always_comb begin
      a_side_in.func = req_payload.func;
      a_side_in.neg  = req_payload.time_value[63];
      a_side_in.bad  = !req_payload.time_numeric || req_payload.time_scale[31]
                       || (req_payload.time_scale == '0)
                       || (frame_value_ff == '0) || (frame_timescale_ff == '0)
                       || !(req_payload.func == FUNC_FLOOR || req_payload.func == FUNC_CEIL
                            || req_payload.func == FUNC_ROUND);
      a_mag_in = req_payload.time_value[63] ? 64'(-req_payload.time_value)
                                            : req_payload.time_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= req_valid;
      end
      if (advance) begin
         a_side_ff <= a_side_in;
         a_mag_ff  <= a_mag_in;
         a_ts_ff   <= req_payload.time_scale[CfgBits-1:0];
      end
   end

   // ---------------- stage B: partial products ----------------
   logic               b_valid_ff;
   side_type           b_side_ff;
   logic [62:0]        b_p0_ff, b_p1_ff;
   logic [DenBits-1:0] b_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
      end
      if (advance) begin
         b_side_ff <= a_side_ff;
         b_p0_ff   <= {31'd0, a_mag_ff[31:0]}  * {32'd0, frame_timescale_ff};
         b_p1_ff   <= {31'd0, a_mag_ff[63:32]} * {32'd0, frame_timescale_ff};
         b_den_ff  <= {31'd0, a_ts_ff} * {31'd0, frame_value_ff};
      end
   end

   // ---------------- stage C: numerator sum ----------------
   logic               c_valid_ff;
   side_type           c_side_ff;
   logic [NumBits-1:0] c_num_ff;
   logic [DenBits-1:0] c_den_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         c_valid_ff <= b_valid_ff;
      end
      if (advance) begin
         c_side_ff <= b_side_ff;
         c_num_ff  <= {32'd0, b_p0_ff} + {b_p1_ff, 32'd0};
         c_den_ff  <= b_den_ff;
      end
   end

   // ---------------- divider ----------------
   logic               q_valid;
   logic [NumBits-1:0] q_quot;
   logic [DenBits-1:0] q_rem, q_den;
   side_type           q_side;

   tsfi_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (c_valid_ff),
      .in_num    (c_num_ff),
      .in_den    (c_den_ff),
      .in_side   (c_side_ff),
      .out_valid (q_valid),
      .out_quot  (q_quot),
      .out_rem   (q_rem),
      .out_den   (q_den),
      .out_side  (q_side)
   );

   // ---------------- rounding, saturation, output register ----------------
   logic             rem_nz, half_ge, half_gt, up;
   logic [NumBits:0] qp;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff;

   always_comb begin
      rem_nz  = q_rem != '0;
      half_ge = {q_rem, 1'b0} >= {1'b0, q_den};
      half_gt = {q_rem, 1'b0} >  {1'b0, q_den};
      case (q_side.func)
         FUNC_FLOOR: up = q_side.neg && rem_nz;
         FUNC_CEIL:  up = !q_side.neg && rem_nz;
         default:    up = q_side.neg ? half_gt : half_ge;
      endcase
      qp = {1'b0, q_quot} + {{NumBits{1'b0}}, up};

      rsp_in.on_grid = !rem_nz;
      if (q_side.neg) begin
         if (qp > {{(NumBits-63){1'b0}}, 1'b1, 63'd0}) begin
            rsp_in.frame_index = {1'b1, 63'd0};
            rsp_in.status      = STATUS_SAT;
         end else begin
            rsp_in.frame_index = 64'(-qp[63:0]);
            rsp_in.status      = STATUS_OK;
         end
      end else begin
         if (qp[NumBits:63] != '0) begin
            rsp_in.frame_index = {1'b0, {63{1'b1}}};
            rsp_in.status      = STATUS_SAT;
         end else begin
            rsp_in.frame_index = qp[63:0];
            rsp_in.status      = STATUS_OK;
         end
      end
      if (q_side.bad) begin
         rsp_in.frame_index = '0;
         rsp_in.on_grid     = 1'b0;
         rsp_in.status      = STATUS_BAD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= q_valid;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // ---------------- assertions ----------------
   a_bad_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_BAD
      |-> rsp_payload.frame_index == '0 && !rsp_payload.on_grid)
      else $error("unusable item with nonzero result");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status != 2'd3)
      else $error("undefined status code");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !a_valid_ff)
      else $error("pipeline not empty after reset");

   a_sat_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == STATUS_SAT
      |-> rsp_payload.frame_index[62:0] == {63{!rsp_payload.frame_index[63]}})
      else $error("saturated index not at a limit");

endmodule

`default_nettype wire

/* rtl/tsfi_divider.sv */
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module tsfi_divider
   import tsfi_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               enable,
   input  wire logic               in_valid,
   input  wire logic [NumBits-1:0] in_num,
   input  wire logic [DenBits-1:0] in_den,
   input  wire side_type           in_side,
   output logic                    out_valid,
   output logic [NumBits-1:0]      out_quot,
   output logic [DenBits-1:0]      out_rem,
   output logic [DenBits-1:0]      out_den,
   output side_type                out_side
);

   // nq: remaining numerator bits on top, quotient bits shifted in below
   logic               valid_ff [1:NumBits];
   logic [NumBits-1:0] nq_ff    [1:NumBits];
   logic [DenBits-1:0] rem_ff   [1:NumBits];
   logic [DenBits-1:0] den_ff   [1:NumBits];
   side_type           side_ff  [1:NumBits];

   for (genvar k = 0; k < NumBits; k++) begin : g_stage
      logic               valid_cur;
      logic [NumBits-1:0] nq_cur;
      logic [DenBits-1:0] rem_cur;
      logic [DenBits-1:0] den_cur;
      side_type           side_cur;
      logic [DenBits:0]   trial;
      logic               fits;
      logic [DenBits-1:0] rem_in;
      logic [NumBits-1:0] nq_in;

      if (k == 0) begin : g_head
         assign valid_cur = in_valid;
         assign nq_cur    = in_num;
         assign rem_cur   = '0;
         assign den_cur   = in_den;
         assign side_cur  = in_side;
      end else begin : g_body
         assign valid_cur = valid_ff[k];
         assign nq_cur    = nq_ff[k];
         assign rem_cur   = rem_ff[k];
         assign den_cur   = den_ff[k];
         assign side_cur  = side_ff[k];
      end

      always_comb begin
         trial  = {rem_cur, nq_cur[NumBits-1]};
         fits   = trial >= {1'b0, den_cur};
         rem_in = fits ? DenBits'(trial - {1'b0, den_cur}) : trial[DenBits-1:0];
         nq_in  = {nq_cur[NumBits-2:0], fits};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k+1] <= 1'b0;
         end else if (enable) begin
            valid_ff[k+1] <= valid_cur;
         end
         if (enable) begin
            nq_ff[k+1]   <= nq_in;
            rem_ff[k+1]  <= rem_in;
            den_ff[k+1]  <= den_cur;
            side_ff[k+1] <= side_cur;
         end
      end
   end

   assign out_valid = valid_ff[NumBits];
   assign out_quot  = nq_ff[NumBits];
   assign out_rem   = rem_ff[NumBits];
   assign out_den   = den_ff[NumBits];
   assign out_side  = side_ff[NumBits];

endmodule

`default_nettype wire

/* tb/timestamp_to_frame_index_test.sv */
// Self-checking testbench for the timestamp to frame index converter.
`default_nettype none

module timestamp_to_frame_index_test;
   import tsfi_pkg::*;

   // func code 3 is not a snap mode; the block must flag it as bad input
   localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
   localparam int         IdleLimit    = 4000;
   localparam int         DrainCycles  = 120;   // pipeline depth plus margin
   localparam logic [63:0] IndexMax    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] IndexMin    = 64'h8000_0000_0000_0000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_payload;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic        csr_index;
   logic [31:0] csr_data;

   timestamp_to_frame_index dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // local copy of the frame duration registers
   logic [30:0] frame_num = 31'd1;
   logic [30:0] frame_rate = 31'd30;

   rsp_type pending_index[$];
   int      failures = 0;
   int      idle_cycles = 0;
   bit      quiet = 1'b0;        // no idling on either side near the end
   bit      long_hold = 1'b0;    // asks the receiver for one long stall

   // Frame index of one timestamp under the current frame duration.
   function automatic rsp_type frame_index_of(req_type it);
      logic [63:0]  mag;
      logic [127:0] num, den, quo, rem;
      logic         neg, up;
      rsp_type      o;
      o.frame_index = '0;
      o.on_grid     = 1'b0;
      o.status      = STATUS_BAD;
      if (!it.time_numeric || it.time_scale <= 0 || frame_num == 0 || frame_rate == 0
          || it.func == FUNC_UNKNOWN)
         return o;
      neg = it.time_value[63];
      mag = it.time_value;
      if (neg) mag = ~mag + 64'd1;
      num = {64'd0, mag} * {97'd0, frame_rate};
      den = {96'd0, it.time_scale[31:0]} * {97'd0, frame_num};
      quo = num / den;
      rem = num % den;
      case (it.func)
         FUNC_FLOOR: up = neg && rem != 0;
         FUNC_CEIL:  up = !neg && rem != 0;
         default:    up = neg ? (2 * rem > den) : (2 * rem >= den);
      endcase
      quo = quo + up;
      o.on_grid = (rem == 0);
      o.status  = STATUS_OK;
      if (neg) begin
         if (quo > {64'd0, IndexMin}) begin
            o.frame_index = IndexMin;
            o.status      = STATUS_SAT;
         end else begin
            o.frame_index = -quo[63:0];
         end
      end else if (quo > {64'd0, IndexMax}) begin
         o.frame_index = IndexMax;
         o.status      = STATUS_SAT;
      end else begin
         o.frame_index = quo[63:0];
      end
      return o;
   endfunction

   // Offer one item; valid stays high on return so back-to-back items need
   // no extra edge.
   task automatic send_item(input req_type it);
      req_payload <= it;
      req_valid   <= 1'b1;
      do @(posedge clock); while (req_stall);
      pending_index.push_back(frame_index_of(it));
   endtask

   task automatic maybe_gap();
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Stop offering and wait until every result is back.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_index.size() != 0) @(posedge clock);
   endtask

   // One register write; valid is dropped again before the task returns.
   task automatic write_csr(input logic idx, input logic [31:0] data);
      csr_index <= idx;
      csr_data  <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_VALUE) frame_num = data[30:0];
      else frame_rate = data[30:0];
      @(posedge clock);
   endtask

   function automatic req_type random_item();
      req_type it;
      it.func = ($urandom_range(0, 15) == 0) ? FUNC_UNKNOWN : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
         0:       it.time_value = {$urandom, $urandom};
         1:       it.time_value = 64'($signed($urandom_range(0, 2000)) - 1000);
         2:       it.time_value = $urandom_range(0, 1) ? IndexMax - $urandom_range(0, 3)
                                                       : IndexMin + $urandom_range(0, 3);
         default: it.time_value = 64'($signed({$urandom, $urandom}) >>> $urandom_range(0, 62));
      endcase
      case ($urandom_range(0, 9))
         0:       it.time_scale = $urandom;                       // often non-positive
         1:       it.time_scale = 32'sh7FFF_FFFF;
         2, 3:    it.time_scale = $urandom_range(1, 100);
         default: it.time_scale = $urandom_range(1, 32'h7FFF_FFFF) >> $urandom_range(0, 30);
      endcase
      if (it.time_scale == 0 && $urandom_range(0, 1)) it.time_scale = 1;
      it.time_numeric = ($urandom_range(0, 19) != 0);
      return it;
   endfunction

   task automatic random_config();
      logic [31:0] fv, fr;
      case ($urandom_range(0, 7))
         0: begin fv = 32'd1;          fr = 32'd30; end
         1: begin fv = 32'd0;          fr = $urandom; end
         2: begin fv = $urandom;       fr = 32'd0; end
         3: begin fv = 32'h7FFF_FFFF;  fr = 32'hFFFF_FFFF; end
         4: begin fv = 32'h8000_0001;  fr = 32'h7FFF_FFFF; end
         5: begin fv = $urandom_range(1, 1001); fr = $urandom_range(1, 120000); end
         default: begin fv = $urandom; fr = $urandom; end
      endcase
      write_csr(CSR_FRAME_VALUE, fv);
      write_csr(CSR_FRAME_TIMESCALE, fr);
   endtask

   // Receiver: short random stalls, plus one long hold on request so the
   // pipeline fills and backs up into the input.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (300) @(posedge clock);
            rsp_stall <= 1'b0;
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 9) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 5)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Result checker: each accepted result against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_index.size() == 0) begin
            $error("result with no item outstanding: %p", rsp_payload);
            failures++;
         end else begin
            want = pending_index.pop_front();
            if (rsp_payload.frame_index !== want.frame_index) begin
               $error("frame_index: expected %0d, got %0d", want.frame_index,
                      rsp_payload.frame_index);
               failures++;
            end
            if (rsp_payload.on_grid !== want.on_grid) begin
               $error("on_grid: expected %0b, got %0b", want.on_grid, rsp_payload.on_grid);
               failures++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               failures++;
            end
         end
      end
   end

   // Watchdog: counts cycles with no handshake on any channel.
   initial begin
      while (idle_cycles < IdleLimit) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("TB_ERROR");
      $finish;
   end

   typedef struct {
      req_type stim;
      bit      known;     // expected result written in the row
      rsp_type want;
   } row_type;

   function automatic req_type mk(logic [1:0] f, logic [63:0] tv, logic [31:0] ts, logic num);
      req_type it;
      it.func = f; it.time_value = tv; it.time_scale = ts; it.time_numeric = num;
      return it;
   endfunction

   function automatic rsp_type res(logic [63:0] fi, logic g, status_type s);
      rsp_type o;
      o.frame_index = fi; o.on_grid = g; o.status = s;
      return o;
   endfunction

   initial begin
      row_type rows[$];
      rsp_type unused;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_payload <= '0;
      csr_valid   <= 1'b0;
      csr_index   <= CSR_FRAME_VALUE;
      csr_data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      unused = res('0, 1'b0, STATUS_BAD);
      // after reset: frame of 1/30 s, so index = value * 30 / scale
      rows.push_back('{mk(FUNC_FLOOR, 64'd1, 32'd1, 1'b1), 1, res(64'd30, 1, STATUS_OK)});
      rows.push_back('{mk(FUNC_FLOOR, 64'd1, 32'd1, 1'b0), 1, unused});        // not numeric
      rows.push_back('{mk(FUNC_CEIL, 64'd5, 32'd0, 1'b1), 1, unused});         // zero scale
      rows.push_back('{mk(FUNC_ROUND, 64'd5, 32'hFFFF_FFFF, 1'b1), 1, unused}); // negative scale
      rows.push_back('{mk(FUNC_FLOOR, 64'd5, 32'h8000_0000, 1'b1), 1, unused});
      rows.push_back('{mk(FUNC_UNKNOWN, 64'd5, 32'd1, 1'b1), 1, unused});
      rows.push_back('{mk(FUNC_FLOOR, IndexMax, 32'd1, 1'b1), 1, res(IndexMax, 1, STATUS_SAT)});
      rows.push_back('{mk(FUNC_CEIL, IndexMin, 32'd1, 1'b1), 1, res(IndexMin, 1, STATUS_SAT)});
      rows.push_back('{mk(FUNC_CEIL, 64'd0, 32'd7, 1'b1), 1, res(64'd0, 1, STATUS_OK)});
      for (int f = 0; f < 3; f++) begin
         rows.push_back('{mk(2'(f), 64'd1, 32'd7, 1'b1), 0, unused});
         rows.push_back('{mk(2'(f), -64'sd1, 32'd7, 1'b1), 0, unused});
         rows.push_back('{mk(2'(f), 64'd1, 32'd60, 1'b1), 0, unused});   // exactly half
         rows.push_back('{mk(2'(f), -64'sd1, 32'd60, 1'b1), 0, unused});
      end
      rows.push_back('{mk(FUNC_ROUND, IndexMax, 32'h7FFF_FFFF, 1'b1), 0, unused});
      rows.push_back('{mk(FUNC_FLOOR, IndexMin, 32'h7FFF_FFFF, 1'b1), 0, unused});
      rows.push_back('{mk(FUNC_CEIL, -64'sd1, 32'h7FFF_FFFF, 1'b1), 0, unused});

      foreach (rows[i]) begin
         send_item(rows[i].stim);
         if (rows[i].known) begin
            // the typed-in value replaces the predictor's expectation
            pending_index[$] = rows[i].want;
         end
      end
      drain();

      // register extremes: zero duration parts make every item bad input
      write_csr(CSR_FRAME_VALUE, 32'd0);
      send_item(mk(FUNC_FLOOR, 64'd9, 32'd3, 1'b1));
      pending_index[$] = unused;
      drain();
      write_csr(CSR_FRAME_VALUE, 32'hFFFF_FFFF);   // bit 31 dropped
      write_csr(CSR_FRAME_TIMESCALE, 32'd0);
      send_item(mk(FUNC_CEIL, 64'd9, 32'd3, 1'b1));
      pending_index[$] = unused;
      drain();
      write_csr(CSR_FRAME_TIMESCALE, 32'h7FFF_FFFF);
      for (int i = 0; i < 10; i++) send_item(random_item());
      drain();

      // receiver holds off while items keep coming: the pipeline fills up
      random_config();
      long_hold = 1'b1;
      for (int i = 0; i < 200; i++) send_item(random_item());
      drain();

      for (int p = 0; p < 7; p++) begin
         random_config();
         for (int i = 0; i < 80; i++) begin
            send_item(random_item());
            maybe_gap();
         end
         drain();
      end

      // last stretch runs at full rate on both sides
      quiet = 1'b1;
      write_csr(CSR_FRAME_VALUE, $urandom_range(1, 1001));
      write_csr(CSR_FRAME_TIMESCALE, $urandom_range(1, 120000));
      for (int i = 0; i < 60; i++) send_item(random_item());
      drain();
      repeat (DrainCycles) @(posedge clock);

      if (failures == 0 && pending_index.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
rtl/tsfi_pkg.sv
rtl/tsfi_divider.sv
rtl/timestamp_to_frame_index.sv
tb/timestamp_to_frame_index_test.sv
